/* hw/rtl/blas_pkg.sv */
// Shared types, register indexes and reset values for the bottle label applicator sequencer.
package blas_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned IN_DATA_W  = 32;
	localparam int unsigned OUT_DATA_W = 40;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LABEL_THR   = 3'd0,
		CFG_BACK_THR    = 3'd1,
		CFG_ACT_DELAY   = 3'd2,
		CFG_LABEL_DELAY = 3'd3,
		CFG_BACK_DELAY  = 3'd4,
		CFG_REL_DELAY   = 3'd5,
		CFG_MIN_RUN     = 3'd6
	} cfg_idx_t;

	localparam logic [11:0] RST_LABEL_THR   = 12'd2750;
	localparam logic [11:0] RST_BACK_THR    = 12'd3500;
	localparam logic [9:0]  RST_ACT_DELAY   = 10'd0;
	localparam logic [15:0] RST_LABEL_DELAY = 16'd300;
	localparam logic [9:0]  RST_BACK_DELAY  = 10'd0;
	localparam logic [15:0] RST_REL_DELAY   = 16'd400;
	localparam logic [15:0] RST_MIN_RUN     = 16'd300;

	// Number of consecutive present ticks that confirm a bottle.
	localparam logic [1:0] PRESENT_CONFIRM = 2'd3;

	typedef struct packed {
		logic brun;
		logic lrun;
		logic bdone;
		logic bpend;
		logic lpend;
		logic act;
	} flags_t;

endpackage

/* hw/rtl/bottle_label_applicator_sequencer.sv */
// Top level of the bottle label applicator sequencer: tick register, sequencing logic, result register.
// An accepted tick is held in the input stage, evaluated from there and loaded into the result
// register, which offers it on the master side; while the master side stalls it waits in the input stage.
// Throughput: one tick per clock while the master side accepts; the only loop is the sequencing state.
// Reset: arst_n clears the tick time, all timestamps, flags, count and cycle time, and loads
// the configuration registers with their default thresholds and delays. No clearing pass.
module bottle_label_applicator_sequencer (
	input  logic                             clk,
	input  logic                             arst_n,
	// Configuration write port.
	input  logic                             cfg_we,
	input  logic [blas_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [blas_pkg::CFG_DATA_W-1:0]  cfg_data,
	// Tick input.
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// tdata from bit 0: bottle_present, skip_back_label, label_cell[11:0], back_cell[11:0], zeros.
	input  logic [blas_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// Result output.
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// tdata from bit 0: actuator_out, label_motor, back_motor, label_led, back_led,
	// bottles_done[15:0], cycle_ms[15:0], zeros.
	output logic [blas_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
	import blas_pkg::*;

	// Configuration registers.
	logic [11:0] label_thr_q, back_thr_q;
	logic [9:0]  act_delay_q, back_delay_q;
	logic [15:0] label_delay_q, rel_delay_q, min_run_q;

	// Input stage holding one tick until it is evaluated.
	logic        valid_s1;
	logic [25:0] data_s1;
	logic        advance;

	// Sequencing state.
	logic [31:0] tick_q, arr_q, act_q, lms_q, lpt_q, bms_q, bpt_q;
	logic [1:0]  run_q;
	flags_t      flags_q;
	logic [15:0] count_q, last_q;

	// Next state.
	logic [31:0] arr_n, act_n, lms_n, lpt_n, bms_n, bpt_n;
	logic [1:0]  run_n;
	flags_t      flags_n;
	logic [15:0] count_n, last_n;

	// Elapsed times since each timestamp; forced to zero when the stamp is taken this tick.
	logic [31:0] d_arr, d_act, d_lms, d_lpt, d_bpt, d_bms;
	logic        det, placed;

	logic        present, skip;
	logic [11:0] lcell, bcell;
	logic        label_led, back_led;

	// Result register.
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	assign present = data_s1[0];
	assign skip    = data_s1[1];
	assign lcell   = data_s1[13:2];
	assign bcell   = data_s1[25:14];

	// The tick is evaluated once the result register is free or is being emptied, so a new
	// tick can enter the input stage in the same cycle.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	assign label_led = lcell > label_thr_q;
	assign back_led  = bcell < back_thr_q;

	// One tick of the sequence: detection, skip switch, extension, label motor, back motor,
	// retraction, in that order, each seeing what the earlier steps left.
	always_comb begin
		run_n   = run_q;
		flags_n = flags_q;
		arr_n   = arr_q;
		act_n   = act_q;
		lms_n   = lms_q;
		lpt_n   = lpt_q;
		bms_n   = bms_q;
		bpt_n   = bpt_q;
		count_n = count_q;
		last_n  = last_q;
		d_arr   = tick_q - arr_q;
		d_act   = tick_q - act_q;
		d_lms   = tick_q - lms_q;
		d_lpt   = tick_q - lpt_q;
		d_bpt   = tick_q - bpt_q;
		d_bms   = tick_q - bms_q;
		det     = flags_q.act || flags_q.lpend;

		// A bottle counts as arrived on the tick it leaves the sensor after being confirmed.
		if (!det) begin
			if (present) begin
				if (run_q < PRESENT_CONFIRM) begin
					run_n = run_q + 2'd1;
				end
			end else begin
				if (run_q >= PRESENT_CONFIRM) begin
					flags_n.lpend = 1'b1;
					flags_n.bpend = 1'b1;
					flags_n.bdone = 1'b0;
					flags_n.lrun  = 1'b0;
					flags_n.brun  = 1'b0;
					arr_n = tick_q;
					d_arr = '0;
					det   = 1'b1;
				end
				run_n = '0;
			end
		end

		if (skip) begin
			flags_n.bpend = 1'b0;
			flags_n.brun  = 1'b0;
			flags_n.bdone = 1'b1;
		end

		if (det && !flags_n.act && (d_arr > {22'd0, act_delay_q})) begin
			flags_n.act = 1'b1;
			act_n = tick_q;
			d_act = '0;
		end

		if (flags_n.lpend && flags_n.act && (d_act > {16'd0, label_delay_q})) begin
			if (!flags_n.lrun) begin
				flags_n.lrun = 1'b1;
				lms_n = tick_q;
				d_lms = '0;
			end
			if ((d_lms > {16'd0, min_run_q}) && label_led) begin
				flags_n.lpend = 1'b0;
				flags_n.lrun  = 1'b0;
				lpt_n = tick_q;
				bpt_n = tick_q;
				d_lpt = '0;
				d_bpt = '0;
			end
		end

		placed = flags_n.act && !flags_n.lpend;

		if (placed && flags_n.bpend && (d_lpt > {22'd0, back_delay_q})) begin
			if (!flags_n.brun) begin
				flags_n.brun = 1'b1;
				bms_n = tick_q;
				d_bms = '0;
			end
			if ((d_bms > {16'd0, min_run_q}) && back_led) begin
				flags_n.bpend = 1'b0;
				flags_n.brun  = 1'b0;
				flags_n.bdone = 1'b1;
				bpt_n = tick_q;
				d_bpt = '0;
				last_n = (|d_arr[31:16]) ? 16'hFFFF : d_arr[15:0];
			end
		end

		if (placed && flags_n.bdone && (d_lpt > {16'd0, rel_delay_q})
				&& (d_bpt > {16'd0, rel_delay_q})) begin
			flags_n = '0;
			if (count_q != 16'hFFFF) begin
				count_n = count_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_thr_q   <= RST_LABEL_THR;
			back_thr_q    <= RST_BACK_THR;
			act_delay_q   <= RST_ACT_DELAY;
			label_delay_q <= RST_LABEL_DELAY;
			back_delay_q  <= RST_BACK_DELAY;
			rel_delay_q   <= RST_REL_DELAY;
			min_run_q     <= RST_MIN_RUN;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_LABEL_THR:   label_thr_q   <= cfg_data[11:0];
				CFG_BACK_THR:    back_thr_q    <= cfg_data[11:0];
				CFG_ACT_DELAY:   act_delay_q   <= cfg_data[9:0];
				CFG_LABEL_DELAY: label_delay_q <= cfg_data;
				CFG_BACK_DELAY:  back_delay_q  <= cfg_data[9:0];
				CFG_REL_DELAY:   rel_delay_q   <= cfg_data;
				CFG_MIN_RUN:     min_run_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			data_s1 <= s_axis_tdata[25:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			run_q   <= '0;
			flags_q <= '0;
			arr_q   <= '0;
			act_q   <= '0;
			lms_q   <= '0;
			lpt_q   <= '0;
			bms_q   <= '0;
			bpt_q   <= '0;
			count_q <= '0;
			last_q  <= '0;
		end else if (advance) begin
			tick_q  <= tick_q + 32'd1;
			run_q   <= run_n;
			flags_q <= flags_n;
			arr_q   <= arr_n;
			act_q   <= act_n;
			lms_q   <= lms_n;
			lpt_q   <= lpt_n;
			bms_q   <= bms_n;
			bpt_q   <= bpt_n;
			count_q <= count_n;
			last_q  <= last_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {3'd0, last_n, count_n, back_led, label_led,
				flags_n.brun, flags_n.lrun, flags_n.act};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
	// The two feed motors never run together.
	assert property (@(posedge clk) disable iff (!arst_n) !(flags_q.lrun && flags_q.brun))
		else $error("label and back motors running together");

	// The label motor runs only with the actuator extended and the label still pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		flags_q.lrun |-> (flags_q.act && flags_q.lpend))
		else $error("label motor running outside its phase");

	// The back motor runs only after the label has been placed.
	assert property (@(posedge clk) disable iff (!arst_n)
		flags_q.brun |-> (flags_q.act && !flags_q.lpend && flags_q.bpend))
		else $error("back motor running outside its phase");

	// A held tick is neither lost nor changed while the result side stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(data_s1)))
		else $error("held tick lost or changed");

	// The bottle count only moves by one, and only when a tick is evaluated.
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(count_q))
		else $error("bottle count changed without a tick");
`endif

endmodule

/* sim/tb_bottle_label_applicator_sequencer.sv */
// Self-checking testbench for the bottle label applicator sequencer.
module tb_bottle_label_applicator_sequencer;

	import blas_pkg::*;

	// The write port has one index that no register answers to; writes there must be ignored.
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

	// Long receiver hold-off, long enough to fill the block and push back on the tick input.
	localparam int HOLD_CYCLES = 300;

	// Only the first few mismatches are printed so a broken block cannot flood the log.
	localparam int REPORT_LINES = 50;

	// Receiver stall patterns, picked at random each time the receiver's pattern counter wraps.
	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_MOSTLY,
		RX_ALTERNATE,
		RX_SPARSE
	} rx_mode_t;

	// One tick transfer, declared from the top bit down so that bottle_present lands in bit 0.
	typedef struct packed {
		logic [11:0] back_cell;
		logic [11:0] label_cell;
		logic        skip;
		logic        present;
	} tick_in_t;

	// One result transfer, again declared from the top bit down; actuator_out is bit 0.
	typedef struct packed {
		logic [15:0] cycle_ms;
		logic [15:0] bottles;
		logic        back_led;
		logic        label_led;
		logic        back_motor;
		logic        label_motor;
		logic        actuator;
	} result_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// Fields from bit 0: bottle_present, skip_back_label, label_cell[11:0], back_cell[11:0], zeros.
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// Fields from bit 0: actuator_out, label_motor, back_motor, label_led, back_led,
	// bottles_done[15:0], cycle_ms[15:0], zeros.
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	bottle_label_applicator_sequencer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Ticks waiting to be driven, and the outputs that the accepted ticks must produce, oldest first.
	tick_in_t ticks_pending[$];
	result_t  outputs_due[$];

	int ticks_queued;
	int ticks_accepted;
	int results_checked;
	int mismatches;
	int settings_used;

	// Copy of the sequencer's configuration as the testbench last wrote it.
	logic [11:0] thr_label   = RST_LABEL_THR;
	logic [11:0] thr_back    = RST_BACK_THR;
	logic [9:0]  dly_extend  = RST_ACT_DELAY;
	logic [15:0] dly_feed    = RST_LABEL_DELAY;
	logic [9:0]  dly_back    = RST_BACK_DELAY;
	logic [15:0] dly_release = RST_REL_DELAY;
	logic [15:0] run_min     = RST_MIN_RUN;

	// Copy of the sequencing state: tick time, presence run, timestamps, flags, count, cycle time.
	logic [31:0] now_tick;
	logic [1:0]  confirm_run;
	logic [31:0] arrive_t;
	logic [31:0] extend_t;
	logic [31:0] feed_start_t;
	logic [31:0] label_done_t;
	logic [31:0] back_start_t;
	logic [31:0] back_done_t;
	flags_t      seq_flags;
	logic [15:0] bottles_finished;
	logic [15:0] cycle_time;
	logic [15:0] longest_cycle;

	// Receiver hold-off request, raised once by the stimulus and served by the receiver process.
	logic hold_arm = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Guard against a hung block: the slowest correct run is far shorter than this.
	initial begin
		#2_000_000;
		$display("tb_bottle_label_applicator_sequencer failed");
		$finish;
	end

	// Advances the predicted sequencer by one 1 ms tick and returns the outputs it should show.
	// The stages run in the same order as in the block: detection, skip switch, actuator
	// extension, label motor, back label motor, retraction.
	function automatic result_t apply_tick(input tick_in_t tk);
		logic [31:0] t;
		logic        busy;
		logic        on_bottle;
		logic [31:0] span;
		result_t     r;
		t = now_tick;
		busy = seq_flags.act | seq_flags.lpend;
		// A bottle is only noticed once it leaves after a long enough presence; while one is
		// being labeled the sensor is not looked at.
		if (!busy) begin
			if (tk.present) begin
				if (confirm_run < PRESENT_CONFIRM)
					confirm_run = confirm_run + 2'd1;
			end else begin
				if (confirm_run >= PRESENT_CONFIRM) begin
					seq_flags.lpend = 1'b1;
					seq_flags.bpend = 1'b1;
					seq_flags.bdone = 1'b0;
					seq_flags.lrun  = 1'b0;
					seq_flags.brun  = 1'b0;
					arrive_t = t;
					busy = 1'b1;
				end
				confirm_run = '0;
			end
		end
		// The skip switch marks the back label as done on every tick it is set, bottle or not.
		if (tk.skip) begin
			seq_flags.bpend = 1'b0;
			seq_flags.brun  = 1'b0;
			seq_flags.bdone = 1'b1;
		end
		if (busy && !seq_flags.act && (t - arrive_t) > dly_extend) begin
			seq_flags.act = 1'b1;
			extend_t = t;
		end
		if (seq_flags.lpend && seq_flags.act && (t - extend_t) > dly_feed) begin
			if (!seq_flags.lrun) begin
				seq_flags.lrun = 1'b1;
				feed_start_t = t;
			end
			if ((t - feed_start_t) > run_min && tk.label_cell > thr_label) begin
				seq_flags.lpend = 1'b0;
				seq_flags.lrun  = 1'b0;
				label_done_t = t;
				back_done_t = t;
			end
		end
		on_bottle = seq_flags.act & ~seq_flags.lpend;
		if (on_bottle && seq_flags.bpend && (t - label_done_t) > dly_back) begin
			if (!seq_flags.brun) begin
				seq_flags.brun = 1'b1;
				back_start_t = t;
			end
			if ((t - back_start_t) > run_min && tk.back_cell < thr_back) begin
				span = t - arrive_t;
				seq_flags.bpend = 1'b0;
				seq_flags.brun  = 1'b0;
				seq_flags.bdone = 1'b1;
				back_done_t = t;
				cycle_time = (span > 32'h0000_FFFF) ? 16'hFFFF : span[15:0];
				if (cycle_time > longest_cycle)
					longest_cycle = cycle_time;
			end
		end
		// Retraction waits out the release delay after both placements, then the count goes up, saturating.
		if (on_bottle && seq_flags.bdone && (t - label_done_t) > dly_release &&
				(t - back_done_t) > dly_release) begin
			seq_flags = '0;
			if (bottles_finished != 16'hFFFF)
				bottles_finished = bottles_finished + 16'd1;
		end
		r.actuator    = seq_flags.act;
		r.label_motor = seq_flags.lrun;
		r.back_motor  = seq_flags.brun;
		r.label_led   = tk.label_cell > thr_label;
		r.back_led    = tk.back_cell < thr_back;
		r.bottles     = bottles_finished;
		r.cycle_ms    = cycle_time;
		now_tick = t + 32'd1;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < REPORT_LINES)
			$display("MISMATCH: %s", msg);
		mismatches++;
	endtask

	// Tick driver. The sender works in bursts of random length with random gaps in between,
	// and a tick stays on the bus until the block takes it. Each accepted transfer is run
	// through the predictor at the edge where it is taken.
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk) begin : drive_ticks
		tick_in_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				outputs_due.push_back(apply_tick(s_axis_tdata[$bits(tick_in_t)-1:0]));
				ticks_accepted++;
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// Keep offering the same tick until it is taken.
			end else if (gap_left != 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (ticks_pending.size() != 0) begin
				nxt = ticks_pending.pop_front();
				s_axis_tdata <= {{(IN_DATA_W-$bits(tick_in_t)){1'b0}}, nxt};
				s_axis_tvalid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					// A gap of zero joins two bursts into one long stretch without idling.
					burst_left = $urandom_range(1, 40);
					gap_left = $urandom_range(0, 6);
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver. It stalls on a pattern that changes each time its counter wraps, and once in the run
	// it holds off for a long stretch while the sender keeps going.
	rx_mode_t    rx_mode = RX_ALWAYS;
	logic [4:0]  rx_count = '0;
	int          hold_left = 0;
	logic        hold_used = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (hold_arm && !hold_used) begin
			hold_used <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			rx_count <= rx_count + 5'd1;
			if (rx_count == '0)
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
			case (rx_mode)
				RX_ALWAYS:    m_axis_tready <= 1'b1;
				RX_MOSTLY:    m_axis_tready <= ($urandom_range(0, 3) != 0);
				RX_ALTERNATE: m_axis_tready <= rx_count[0];
				RX_SPARSE:    m_axis_tready <= ($urandom_range(0, 3) == 0);
				default:      m_axis_tready <= 1'b1;
			endcase
		end
	end

	// Result monitor: every result transfer is compared field by field with the oldest
	// outstanding prediction.
	always @(posedge clk) begin : check_results
		result_t want;
		result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (outputs_due.size() == 0) begin
				report_mismatch($sformatf("result transfer %0d arrived with no tick outstanding",
					results_checked));
			end else begin
				want = outputs_due.pop_front();
				got = m_axis_tdata[$bits(result_t)-1:0];
				if (got.actuator !== want.actuator)
					report_mismatch($sformatf("result %0d actuator_out got %b expected %b",
						results_checked, got.actuator, want.actuator));
				if (got.label_motor !== want.label_motor)
					report_mismatch($sformatf("result %0d label_motor got %b expected %b",
						results_checked, got.label_motor, want.label_motor));
				if (got.back_motor !== want.back_motor)
					report_mismatch($sformatf("result %0d back_motor got %b expected %b",
						results_checked, got.back_motor, want.back_motor));
				if (got.label_led !== want.label_led)
					report_mismatch($sformatf("result %0d label_led got %b expected %b",
						results_checked, got.label_led, want.label_led));
				if (got.back_led !== want.back_led)
					report_mismatch($sformatf("result %0d back_led got %b expected %b",
						results_checked, got.back_led, want.back_led));
				if (got.bottles !== want.bottles)
					report_mismatch($sformatf("result %0d bottles_done got %0d expected %0d",
						results_checked, got.bottles, want.bottles));
				if (got.cycle_ms !== want.cycle_ms)
					report_mismatch($sformatf("result %0d cycle_ms got %0d expected %0d",
						results_checked, got.cycle_ms, want.cycle_ms));
			end
			results_checked++;
		end
	end

	// Queues one tick for the driver.
	function automatic void push_tick(input logic present, input logic skip,
			input logic [11:0] label_cell, input logic [11:0] back_cell);
		tick_in_t tk;
		tk.present    = present;
		tk.skip       = skip;
		tk.label_cell = label_cell;
		tk.back_cell  = back_cell;
		ticks_pending.push_back(tk);
		ticks_queued++;
	endfunction

	// Photocell reading that often sits right at a threshold or at the ends of the range.
	function automatic logic [11:0] pick_cell(input logic [11:0] thr);
		int v;
		case ($urandom_range(0, 7))
			0: v = 0;
			1: v = 4095;
			2, 3: v = int'(thr) + int'($urandom_range(0, 2)) - 1;
			default: v = $urandom_range(0, 4095);
		endcase
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return v[11:0];
	endfunction

	// A well-formed bottle: a confirmed presence, its release, then a stretch of photocell
	// readings. The sensor is sometimes set again while the bottle is busy, and on some
	// bottles the skip switch is toggled.
	function automatic void queue_bottle(input int body);
		logic use_skip;
		use_skip = ($urandom_range(0, 2) == 0);
		repeat ($urandom_range(3, 5))
			push_tick(1'b1, 1'b0, pick_cell(thr_label), pick_cell(thr_back));
		repeat (body)
			push_tick($urandom_range(0, 9) == 0, use_skip && ($urandom_range(0, 4) == 0),
				pick_cell(thr_label), pick_cell(thr_back));
	endfunction

	// Noise: presence runs too short to confirm a bottle, with random readings.
	function automatic void queue_glitch();
		repeat ($urandom_range(1, 2))
			push_tick(1'b1, $urandom_range(0, 7) == 0, 12'($urandom_range(0, 4095)),
				12'($urandom_range(0, 4095)));
		push_tick(1'b0, 1'b0, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
	endfunction

	// Writes one register while the block is idle and mirrors the write in the prediction.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_LABEL_THR:   thr_label   = val[11:0];
			CFG_BACK_THR:    thr_back    = val[11:0];
			CFG_ACT_DELAY:   dly_extend  = val[9:0];
			CFG_LABEL_DELAY: dly_feed    = val[15:0];
			CFG_BACK_DELAY:  dly_back    = val[9:0];
			CFG_REL_DELAY:   dly_release = val[15:0];
			CFG_MIN_RUN:     run_min     = val[15:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [11:0] lthr, input logic [11:0] bthr,
			input logic [9:0] ext, input logic [15:0] feed, input logic [9:0] back,
			input logic [15:0] rel, input logic [15:0] run);
		write_reg(CFG_LABEL_THR, {4'd0, lthr});
		write_reg(CFG_BACK_THR, {4'd0, bthr});
		write_reg(CFG_ACT_DELAY, {6'd0, ext});
		write_reg(CFG_LABEL_DELAY, feed);
		write_reg(CFG_BACK_DELAY, {6'd0, back});
		write_reg(CFG_REL_DELAY, rel);
		write_reg(CFG_MIN_RUN, run);
		settings_used++;
	endtask

	// Waits until every queued tick has been taken and every prediction has been met,
	// then lets the input stage and result register run dry.
	task automatic wait_idle();
		while (ticks_accepted != ticks_queued || outputs_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Feeds readings that end every stage until the predicted sequencer is back at rest.
	// Needs short delays and thresholds away from the ends of the range.
	task automatic drain_bottle();
		int tries;
		tries = 0;
		while (seq_flags != '0 && tries < 20) begin
			repeat (30) push_tick(1'b0, 1'b0, 12'd4095, 12'd0);
			wait_idle();
			tries++;
		end
	endtask

	initial begin : stimulus
		int start_items;
		int sub_items;
		logic zero_delays;
		now_tick = '0;
		confirm_run = '0;
		arrive_t = '0;
		extend_t = '0;
		feed_start_t = '0;
		label_done_t = '0;
		back_start_t = '0;
		back_done_t = '0;
		seq_flags = '0;
		bottles_finished = '0;
		cycle_time = '0;
		longest_cycle = '0;
		settings_used = 1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed ticks at the reset settings: LED thresholds hit exactly and one past,
		// readings at both ends, the skip switch with no bottle, a presence too short to
		// count, a real detection, then the sensor and the switch while the bottle is busy.
		push_tick(1'b0, 1'b0, 12'd0, 12'd0);
		push_tick(1'b0, 1'b0, 12'd4095, 12'd4095);
		push_tick(1'b0, 1'b0, 12'd2750, 12'd3500);
		push_tick(1'b0, 1'b0, 12'd2751, 12'd3499);
		push_tick(1'b0, 1'b1, 12'd0, 12'd4095);
		push_tick(1'b1, 1'b0, 12'd100, 12'd100);
		push_tick(1'b1, 1'b0, 12'd100, 12'd100);
		push_tick(1'b0, 1'b0, 12'd100, 12'd100);
		repeat (4) push_tick(1'b1, 1'b0, 12'd2000, 12'd3000);
		push_tick(1'b0, 1'b0, 12'd2000, 12'd3000);
		push_tick(1'b0, 1'b0, 12'd2000, 12'd3000);
		push_tick(1'b1, 1'b1, 12'd4095, 12'd0);
		push_tick(1'b1, 1'b0, 12'd0, 12'd4095);
		push_tick(1'b0, 1'b0, 12'h555, 12'hAAA);
		push_tick(1'b0, 1'b0, 12'hAAA, 12'h555);
		wait_idle();

		// Every register at its far end, plus a write to the unused index that must change
		// nothing. The bottle already in flight simply waits under these settings.
		write_reg(CFG_IDX_UNUSED, 16'hFFFF);
		write_all(12'd4095, 12'd0, 10'd1000, 16'hFFFF, 10'd1000, 16'hFFFF, 16'hFFFF);
		queue_bottle(20);
		wait_idle();

		// Short delays let that bottle finish.
		write_all(12'd2000, 12'd2000, 10'd1, 16'd2, 10'd1, 16'd3, 16'd2);
		drain_bottle();

		// Random part: short random settings per phase, mostly whole bottles with noise mixed
		// in. The first phase starts all delays at zero and triggers the long receiver hold.
		start_items = ticks_queued;
		zero_delays = 1'b1;
		while (ticks_queued - start_items < 300) begin
			if (zero_delays)
				write_all(12'($urandom_range(800, 3300)), 12'($urandom_range(800, 3300)),
					10'd0, 16'd0, 10'd0, 16'd0, 16'd0);
			else
				write_all(12'($urandom_range(500, 3600)), 12'($urandom_range(500, 3600)),
					10'($urandom_range(0, 4)), 16'($urandom_range(0, 5)),
					10'($urandom_range(0, 4)), 16'($urandom_range(0, 6)),
					16'($urandom_range(0, 5)));
			sub_items = ticks_queued;
			while (ticks_queued - sub_items < 80) begin
				if ($urandom_range(0, 3) != 0)
					queue_bottle($urandom_range(10, 40));
				else
					queue_glitch();
			end
			if (zero_delays)
				hold_arm <= 1'b1;
			zero_delays = 1'b0;
			wait_idle();
		end

		$display("Run covered %0d tick transfers and %0d result transfers over %0d settings.",
			ticks_accepted, results_checked, settings_used);
		$display("Bottles labeled: %0d; longest cycle time seen: %0d ms.",
			bottles_finished, longest_cycle);
		if (mismatches == 0) begin
			$display("tb_bottle_label_applicator_sequencer passed");
		end else begin
			$display("tb_bottle_label_applicator_sequencer failed");
		end
		$finish;
	end

endmodule
